// ===== design/i2cm_pkg.sv =====
// Shared types, codes and constants of the I2C master byte engine.
package i2cm_pkg;

   localparam int unsigned TicksW   = 16;
   localparam int unsigned TimeoutW = 8;
   localparam int unsigned CsrIdxW  = 1;
   localparam int unsigned CsrDataW = 16;

   localparam logic [TicksW-1:0]   TICKS_RESET   = 16'd100;
   localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 8'd250;

   localparam logic [CsrIdxW-1:0] CSR_TICKS_PER_UNIT = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_ACK_TIMEOUT    = 1'd1;

   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_START = 3'd1;
   localparam logic [2:0] FUNC_STOP  = 3'd2;
   localparam logic [2:0] FUNC_WRITE = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_missing;
   } rsp_item_type;

   typedef struct packed {
      logic [TicksW-1:0]   ticks_per_unit;
      logic [TimeoutW-1:0] ack_timeout;
   } cfg_type;

endpackage

// ===== design/i2cm_seq.sv =====
// Pin sequencer: engine state registers and the per-item next-state logic.
module i2cm_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  i2cm_pkg::req_item_type item,
   input  i2cm_pkg::cfg_type      cfg,
   output i2cm_pkg::rsp_item_type result
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_HI, PH_ST_LO, PH_SP_A, PH_SP_B, PH_SP_C,
      PH_WR_LOW, PH_WR_HIGH, PH_AK_LOW, PH_AK_HIGH, PH_POLL,
      PH_RD_LOW, PH_RD_HIGH, PH_AC_A, PH_AC_B
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [3:0]                   bit_ff, bit_in;
   logic [7:0]                   shift_ff, shift_in;
   logic [i2cm_pkg::TicksW-1:0]  delay_ff, delay_in;
   logic [8:0]                   poll_ff, poll_in;
   logic [1:0]                   units_ff, units_in;
   logic                         scl_ff, scl_in;
   logic                         sda_ff, sda_in_nx;
   logic                         drv_ff, drv_in;
   logic                         ackc_ff, ackc_in;
   logic                         miss_ff, miss_in;
   logic [7:0]                   last_ff, last_in;

   logic                         finished;
   logic [i2cm_pkg::TicksW-1:0]  unit;
   logic [i2cm_pkg::TicksW:0]    delay_inc;
   logic [1:0]                   units_dec;
   logic [3:0]                   bit_inc;
   logic [7:0]                   shift_rd;
   logic                         is_cmd;

   always_comb begin
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      delay_in  = delay_ff;
      poll_in   = poll_ff;
      units_in  = units_ff;
      scl_in    = scl_ff;
      sda_in_nx = sda_ff;
      drv_in    = drv_ff;
      ackc_in   = ackc_ff;
      miss_in   = miss_ff;
      last_in   = last_ff;
      finished  = 1'b0;

      unit      = (cfg.ticks_per_unit == '0) ? i2cm_pkg::TicksW'(1) : cfg.ticks_per_unit;
      delay_inc = {1'b0, delay_ff} + (i2cm_pkg::TicksW+1)'(1);
      units_dec = (units_ff != 2'd0) ? units_ff - 2'd1 : 2'd0;
      bit_inc   = bit_ff + 4'd1;
      shift_rd  = {shift_ff[6:0], item.sda_in};
      is_cmd    = (item.func == i2cm_pkg::FUNC_START) || (item.func == i2cm_pkg::FUNC_STOP) ||
                  (item.func == i2cm_pkg::FUNC_WRITE) || (item.func == i2cm_pkg::FUNC_READ);

      if (phase_ff == PH_IDLE && is_cmd) begin
         miss_in  = 1'b0;
         bit_in   = 4'd0;
         poll_in  = 9'd0;
         delay_in = '0;
         case (item.func)
            i2cm_pkg::FUNC_START: begin
               scl_in    = 1'b1;
               drv_in    = 1'b1;
               sda_in_nx = 1'b1;
               units_in  = 2'd2;
               phase_in  = PH_ST_HI;
            end
            i2cm_pkg::FUNC_STOP: begin
               scl_in    = 1'b0;
               drv_in    = 1'b1;
               sda_in_nx = 1'b0;
               units_in  = 2'd2;
               phase_in  = PH_SP_A;
            end
            i2cm_pkg::FUNC_WRITE: begin
               shift_in = item.data_byte;
               scl_in   = 1'b0;
               units_in = 2'd1;
               phase_in = PH_WR_LOW;
            end
            default: begin
               ackc_in   = item.send_ack;
               shift_in  = 8'd0;
               scl_in    = 1'b0;
               drv_in    = 1'b0;
               sda_in_nx = 1'b1;
               units_in  = 2'd2;
               phase_in  = PH_RD_LOW;
            end
         endcase
      end else if (phase_ff == PH_POLL) begin
         if (!item.sda_in) begin
            scl_in   = 1'b0;
            phase_in = PH_IDLE;
            units_in = 2'd0;
            delay_in = '0;
            finished = 1'b1;
         end else if (poll_ff > {1'b0, cfg.ack_timeout}) begin
            // No acknowledge in time: flag it and run a stop sequence.
            miss_in   = 1'b1;
            scl_in    = 1'b0;
            drv_in    = 1'b1;
            sda_in_nx = 1'b0;
            units_in  = 2'd2;
            delay_in  = '0;
            phase_in  = PH_SP_A;
         end else begin
            poll_in = poll_ff + 9'd1;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (delay_inc >= {1'b0, unit}) begin
            delay_in = '0;
            units_in = units_dec;
            if (units_dec == 2'd0) begin
               case (phase_ff)
                  PH_ST_HI: begin
                     drv_in    = 1'b1;
                     sda_in_nx = 1'b0;
                     units_in  = 2'd2;
                     phase_in  = PH_ST_LO;
                  end
                  PH_ST_LO: begin
                     scl_in   = 1'b0;
                     phase_in = PH_IDLE;
                     finished = 1'b1;
                  end
                  PH_SP_A: begin
                     scl_in   = 1'b1;
                     units_in = 2'd1;
                     phase_in = PH_SP_B;
                  end
                  PH_SP_B: begin
                     drv_in    = 1'b1;
                     sda_in_nx = 1'b1;
                     units_in  = 2'd2;
                     phase_in  = PH_SP_C;
                  end
                  PH_WR_LOW: begin
                     drv_in    = 1'b1;
                     sda_in_nx = shift_ff[7];
                     shift_in  = {shift_ff[6:0], 1'b0};
                     scl_in    = 1'b1;
                     units_in  = 2'd2;
                     phase_in  = PH_WR_HIGH;
                  end
                  PH_WR_HIGH: begin
                     bit_in   = bit_inc;
                     scl_in   = 1'b0;
                     units_in = 2'd1;
                     if (bit_inc < 4'd8) begin
                        phase_in = PH_WR_LOW;
                     end else begin
                        drv_in    = 1'b0;
                        sda_in_nx = 1'b1;
                        phase_in  = PH_AK_LOW;
                     end
                  end
                  PH_AK_LOW: begin
                     scl_in   = 1'b1;
                     units_in = 2'd1;
                     phase_in = PH_AK_HIGH;
                  end
                  PH_AK_HIGH: begin
                     // First poll happens on the tick that ends the high phase.
                     if (!item.sda_in) begin
                        scl_in   = 1'b0;
                        poll_in  = 9'd0;
                        phase_in = PH_IDLE;
                        finished = 1'b1;
                     end else begin
                        poll_in  = 9'd1;
                        phase_in = PH_POLL;
                     end
                  end
                  PH_RD_LOW: begin
                     scl_in   = 1'b1;
                     units_in = 2'd2;
                     phase_in = PH_RD_HIGH;
                  end
                  PH_RD_HIGH: begin
                     shift_in = shift_rd;
                     bit_in   = bit_inc;
                     scl_in   = 1'b0;
                     units_in = 2'd2;
                     if (bit_inc < 4'd8) begin
                        drv_in    = 1'b0;
                        sda_in_nx = 1'b1;
                        phase_in  = PH_RD_LOW;
                     end else begin
                        last_in   = shift_rd;
                        drv_in    = 1'b1;
                        sda_in_nx = ~ackc_ff;
                        phase_in  = PH_AC_A;
                     end
                  end
                  PH_AC_A: begin
                     scl_in   = 1'b1;
                     units_in = 2'd2;
                     phase_in = PH_AC_B;
                  end
                  PH_AC_B: begin
                     scl_in   = 1'b0;
                     phase_in = PH_IDLE;
                     finished = 1'b1;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     finished = 1'b1;
                  end
               endcase
            end
         end else begin
            delay_in = delay_inc[i2cm_pkg::TicksW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         delay_ff <= '0;
         poll_ff  <= 9'd0;
         units_ff <= 2'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b1;
         ackc_ff  <= 1'b0;
         miss_ff  <= 1'b0;
         last_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         delay_ff <= delay_in;
         poll_ff  <= poll_in;
         units_ff <= units_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_nx;
         drv_ff   <= drv_in;
         ackc_ff  <= ackc_in;
         miss_ff  <= miss_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      result.scl         = scl_in;
      result.sda_out     = drv_in ? sda_in_nx : 1'b1;
      result.sda_drive   = drv_in;
      result.busy_res    = (phase_in != PH_IDLE);
      result.done_res    = finished;
      result.read_byte   = last_in;
      result.ack_missing = miss_in;
   end

endmodule

// ===== design/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: handshake registers and configuration.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   i2cm_pkg::req_item_type
//   rsp_      out        rsp_valid/rsp_stall   i2cm_pkg::rsp_item_type
//   csr_      in         csr_we                csr_index, csr_wdata
//
// One item per clock cycle sustained while the result is not stalled;
// each item passes from acceptance through the input register, then the
// sequencer's next-state logic into the result register. Reset is synchronous and
// returns the pins to SCL high, SDA driven high, and the registers to
// their defaults. A stalled result holds the pipeline; the input side
// keeps accepting while the input register can still move forward.
module i2c_master_byte_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  i2cm_pkg::req_item_type             req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output i2cm_pkg::rsp_item_type             rsp_item,
   input  logic                              csr_we,
   input  logic [i2cm_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [i2cm_pkg::CsrDataW-1:0]      csr_wdata
);

   logic                    in_valid_ff;
   i2cm_pkg::req_item_type  in_item_ff;
   logic                    out_valid_ff;
   i2cm_pkg::rsp_item_type  out_item_ff;
   i2cm_pkg::cfg_type       cfg_ff;
   i2cm_pkg::rsp_item_type  step_result;
   logic                    advance;
   logic                    take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff.ticks_per_unit <= i2cm_pkg::TICKS_RESET;
         cfg_ff.ack_timeout    <= i2cm_pkg::TIMEOUT_RESET;
      end else begin
         if (!in_valid_ff || advance) begin
            in_valid_ff <= take;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               i2cm_pkg::CSR_TICKS_PER_UNIT: cfg_ff.ticks_per_unit <= csr_wdata;
               i2cm_pkg::CSR_ACK_TIMEOUT:
                  cfg_ff.ack_timeout <= csr_wdata[i2cm_pkg::TimeoutW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   i2cm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== design/i2cm_checker.sv =====
// Port-level checks for the I2C master byte engine, bound to the top level.
module i2cm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input i2cm_pkg::rsp_item_type rsp_item
);

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // A finished command leaves the engine idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.done_res |-> !rsp_item.busy_res)
      else $error("done reported while busy");

   // A released SDA line reads as high.
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.sda_drive |-> rsp_item.sda_out)
      else $error("released SDA shown low");

   // A write that gave up on the acknowledge ends with a stop: both lines high.
   a_timeout_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.done_res && rsp_item.ack_missing
         |-> rsp_item.scl && rsp_item.sda_out && rsp_item.sda_drive)
      else $error("ack timeout did not end in a stop");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
